// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the fuzzy speed map RTL.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/fsmap_pkg.sv -----
// Types, constants and rule tables of the fuzzy speed map.
// Used by every module of the core; depends on nothing.
package fsmap_pkg;

	localparam int P_SEGS = 12;
	localparam int D_SEGS = 6;
	localparam int D_COLS = 7;
	localparam int RULES  = 91;
	localparam int LEVELS = 13;

	localparam logic signed [11:0] C_LO = -12'sd110;
	localparam logic signed [11:0] C_HI = 12'sd110;
	localparam logic signed [11:0] L_HI = 12'sd45;
	localparam logic [7:0] C_SPAN = 8'd220;
	localparam logic [5:0] L_SPAN = 6'd45;

	// Scale factors folded with the ceiling reciprocals of 55 and 15.
	localparam logic [24:0] P_SCALE = 25'd114408;
	localparam logic [23:0] D_SCALE = 24'd139840;
	// Reciprocal of 10000 at 36 fraction bits.
	localparam logic [22:0] DIV_RECIP = 23'd6871948;

	localparam logic [6:0] GRID_LO = 7'd2;
	localparam logic [6:0] GRID_HI = 7'd98;
	localparam logic [6:0] FULL    = 7'd100;

	localparam logic [3:0] RULE_ROM [RULES] = '{
		4'd4, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
		4'd4, 4'd1, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0,
		4'd5, 4'd2, 4'd1, 4'd1, 4'd0, 4'd0, 4'd0,
		4'd5, 4'd3, 4'd2, 4'd1, 4'd1, 4'd0, 4'd0,
		4'd6, 4'd4, 4'd3, 4'd2, 4'd1, 4'd1, 4'd0,
		4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd1,
		4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
		4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd11,
		4'd6, 4'd8, 4'd9, 4'd10, 4'd11, 4'd11, 4'd12,
		4'd7, 4'd9, 4'd10, 4'd11, 4'd11, 4'd12, 4'd12,
		4'd7, 4'd10, 4'd11, 4'd11, 4'd12, 4'd12, 4'd12,
		4'd8, 4'd11, 4'd11, 4'd12, 4'd12, 4'd12, 4'd12,
		4'd8, 4'd11, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12
	};

	localparam logic signed [9:0] LEVEL_ROM [LEVELS] = '{
		-10'sd350, -10'sd290, -10'sd240, -10'sd180, -10'sd130, -10'sd70, 10'sd0,
		10'sd70, 10'sd130, 10'sd180, 10'sd240, 10'sd290, 10'sd350
	};

	typedef struct packed {
		logic [3:0] pn;
		logic [2:0] dn;
		logic [6:0] pf1;
		logic [6:0] df1;
	} item_t;

	typedef struct packed {
		logic v_s1;
		logic v_s2;
	} front_stat_t;

	function automatic logic signed [9:0] level_at(input logic [3:0] pi, input logic [2:0] di);
		logic [6:0] idx;
		logic [3:0] r;
		idx = 7'({3'b000, pi} * 7'd7) + {4'b0000, di};
		if (idx >= 7'(RULES)) begin
			r = RULE_ROM[0];
		end else begin
			r = RULE_ROM[idx];
		end
		if (r >= 4'(LEVELS)) begin
			r = 4'(LEVELS - 1);
		end
		return LEVEL_ROM[r];
	endfunction

endpackage

// ----- rtl/core/fsmap_front.sv -----
// Front end of the fuzzy speed map: clamps and scales a sample, then places it on the grids.
// Depends on fsmap_pkg.
module fsmap_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic signed [11:0]        complexity,
	input  logic signed [11:0]        lookahead,
	output logic                      push,
	output fsmap_pkg::item_t          item,
	output fsmap_pkg::front_stat_t    stat
);
	import fsmap_pkg::*;

	logic [7:0]  c_off;
	logic [5:0]  l_off;
	logic [24:0] p_prod;
	logic [23:0] d_prod;
	logic        v_s1;
	logic [6:0]  p_s1;
	logic [6:0]  d_s1;
	logic        v_s2;
	item_t       item_s2;
	item_t       item_c;
	logic [7:0]  p_sum;
	logic [7:0]  d_sum;
	logic [3:0]  p_n;
	logic [2:0]  d_n;
	logic [6:0]  p_up;
	logic [6:0]  d_up;
	logic [2:0]  p_r;
	logic [3:0]  d_r;
	logic [6:0]  p_f0;
	logic [6:0]  d_f0;

	always_comb begin
		if (complexity < C_LO) begin
			c_off = 8'd0;
		end else if (complexity > C_HI) begin
			c_off = C_SPAN;
		end else begin
			c_off = 8'(complexity - C_LO);
		end
		if (lookahead < 12'sd0) begin
			l_off = 6'd0;
		end else if (lookahead > L_HI) begin
			l_off = L_SPAN;
		end else begin
			l_off = lookahead[5:0];
		end
		p_prod = 25'(c_off) * P_SCALE;
		d_prod = 24'(l_off) * D_SCALE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_s1 <= p_prod[24:18] + GRID_LO;
		d_s1 <= 7'(d_prod[23:16]) + GRID_LO;
		item_s2 <= item_c;
	end

	always_comb begin
		p_sum = 8'(p_s1) + 8'd5;
		d_sum = 8'(d_s1) + 8'd13;
		p_n = p_sum[6:3];
		d_n = d_sum[6:4];
		p_up = GRID_LO + {p_n, 3'b000};
		d_up = GRID_LO + {d_n, 4'b0000};
		p_r = 3'(p_up - p_s1);
		d_r = 4'(d_up - d_s1);
		p_f0 = 7'((10'(p_r) * 10'd100) >> 3);
		d_f0 = 7'((11'(d_r) * 11'd100) >> 4);
		if (p_s1 <= GRID_LO) begin
			item_c.pn = 4'd1;
			p_f0 = FULL;
		end else if (p_s1 >= GRID_HI) begin
			item_c.pn = 4'(P_SEGS);
			p_f0 = 7'd0;
		end else begin
			item_c.pn = p_n;
		end
		if (d_s1 <= GRID_LO) begin
			item_c.dn = 3'd1;
			d_f0 = FULL;
		end else if (d_s1 >= GRID_HI) begin
			item_c.dn = 3'(D_SEGS);
			d_f0 = 7'd0;
		end else begin
			item_c.dn = d_n;
		end
		item_c.pf1 = FULL - p_f0;
		item_c.df1 = FULL - d_f0;
	end

	assign push = v_s2;
	assign item = item_s2;
	assign stat.v_s1 = v_s1;
	assign stat.v_s2 = v_s2;

endmodule

// ----- rtl/core/fsmap_queue.sv -----
// Short queue between the front and back ends of the fuzzy speed map.
// Depends on fsmap_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fsmap_queue #(
	parameter int DEPTH = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  fsmap_pkg::item_t              wr_item,
	input  logic                          pop,
	output logic                          rd_valid,
	output fsmap_pkg::item_t              rd_item,
	output logic [$clog2(DEPTH+1)-1:0]    count
);
	import fsmap_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t          slot_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign rd_valid = (count_q != '0);
	assign rd_item  = slot_q[rd_ptr_q];
	assign count    = count_q;

	`ASSERT_IMPLY(a_no_overflow, clk, arst_n, push, count_q < CW'(DEPTH), "queue written while full")
	`ASSERT_NEXT(a_push_fills, clk, arst_n, push && !pop, count_q != '0, "pushed item was lost")

endmodule

// ----- rtl/core/fsmap_back.sv -----
// Back end of the fuzzy speed map: rule lookup, bilinear blend and exact division by 10000.
// Depends on fsmap_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fsmap_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  fsmap_pkg::item_t      in_item,
	output logic                  done,
	output logic signed [9:0]     speed_diff
);
	import fsmap_pkg::*;

	logic                v_b1;
	logic signed [9:0]   u0_b1;
	logic signed [9:0]   u1_b1;
	logic signed [9:0]   u2_b1;
	logic signed [9:0]   u3_b1;
	logic [6:0]          pf1_b1;
	logic [6:0]          df1_b1;
	logic                v_b2;
	logic signed [16:0]  t1_b2;
	logic signed [16:0]  t2_b2;
	logic [6:0]          pf1_b2;
	logic                v_b3;
	logic signed [22:0]  acc_b3;
	logic                v_b4;
	logic                neg_b4;
	logic [8:0]          quo_b4;
	logic                done_q;
	logic signed [9:0]   speed_diff_q;

	logic [3:0]          pi0;
	logic [2:0]          di0;
	logic signed [18:0]  t1_c;
	logic signed [18:0]  t2_c;
	logic signed [17:0]  dt_c;
	logic signed [24:0]  acc_c;
	logic [21:0]         mag_c;
	logic [44:0]         prod_c;

	assign pi0 = in_item.pn - 4'd1;
	assign di0 = in_item.dn - 3'd1;

	always_comb begin
		t1_c = 19'(u0_b1) * 19'sd100
			+ $signed({12'b0, df1_b1}) * (19'(u2_b1) - 19'(u0_b1));
		t2_c = 19'(u1_b1) * 19'sd100
			+ $signed({12'b0, df1_b1}) * (19'(u3_b1) - 19'(u1_b1));
		dt_c = 18'(t2_b2) - 18'(t1_b2);
		acc_c = 25'(t1_b2) * 25'sd100 + $signed({18'b0, pf1_b2}) * 25'(dt_c);
		mag_c = acc_b3[22] ? 22'(-acc_b3) : 22'(acc_b3);
		prod_c = 45'(mag_c) * 45'(DIV_RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1   <= 1'b0;
			v_b2   <= 1'b0;
			v_b3   <= 1'b0;
			v_b4   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_b1   <= in_valid;
			v_b2   <= v_b1;
			v_b3   <= v_b2;
			v_b4   <= v_b3;
			done_q <= v_b4;
		end
	end

	always_ff @(posedge clk) begin
		u0_b1  <= level_at(pi0, di0);
		u1_b1  <= level_at(in_item.pn, di0);
		u2_b1  <= level_at(pi0, in_item.dn);
		u3_b1  <= level_at(in_item.pn, in_item.dn);
		pf1_b1 <= in_item.pf1;
		df1_b1 <= in_item.df1;
		t1_b2  <= 17'(t1_c);
		t2_b2  <= 17'(t2_c);
		pf1_b2 <= pf1_b1;
		acc_b3 <= 23'(acc_c);
		neg_b4 <= acc_b3[22];
		quo_b4 <= prod_c[44:36];
		speed_diff_q <= neg_b4 ? -10'(quo_b4) : 10'(quo_b4);
	end

	assign done       = done_q;
	assign speed_diff = speed_diff_q;

	`ASSERT_IMPLY(a_fixed_latency, clk, arst_n, v_b1, ##4 done_q, "result strobe missing")
	`ASSERT_IMPLY(a_result_range, clk, arst_n, done_q, (speed_diff_q <= 10'sd350) && (speed_diff_q >= -10'sd350), "result out of range")

endmodule

// ----- rtl/core/fuzzy_speed_map_core.sv -----
// Top level of the fuzzy speed map core.
// Depends on fsmap_pkg, fsmap_front, fsmap_queue and fsmap_back.
//
// A sample (complexity, lookahead) is taken at a rising edge where start is high and
// busy is low. The front end clamps, scales and grid-locates it in two register stages
// and writes the result into a short queue. The back end pops one queue entry per cycle
// and runs it through a five-stage pipeline: rule and level lookup, two blend stages,
// the reciprocal multiply for the division by 10000, and the output register.
// A result appears on speed_diff with done high for exactly one cycle, after its sample
// has passed the front end, the queue and the back end; results leave in sample order.
// One sample can be accepted every cycle while busy is low. busy rises only when the
// queue plus the samples still in the front end fill QUEUE_DEPTH entries.
// The receiver cannot hold results off, so the back end never stalls and busy stays
// low in normal use.
// Reset clears all valid flags and the queue, dropping samples in flight; it creates none.
module fuzzy_speed_map_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [11:0] complexity,
	input  logic signed [11:0] lookahead,
	output logic               done,
	output logic signed [9:0]  speed_diff
);
	import fsmap_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int OW = $clog2(QUEUE_DEPTH + 3);

	logic           accept;
	logic           push;
	item_t          fr_item;
	front_stat_t    fr_stat;
	logic           q_valid;
	item_t          q_item;
	logic [CW-1:0]  q_count;
	logic [OW-1:0]  occupancy;

	assign occupancy = OW'(q_count) + OW'(fr_stat.v_s1) + OW'(fr_stat.v_s2);
	assign busy      = (occupancy >= OW'(QUEUE_DEPTH));
	assign accept    = start && !busy;

	fsmap_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.complexity (complexity),
		.lookahead  (lookahead),
		.push       (push),
		.item       (fr_item),
		.stat       (fr_stat)
	);

	fsmap_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_item  (fr_item),
		.pop      (q_valid),
		.rd_valid (q_valid),
		.rd_item  (q_item),
		.count    (q_count)
	);

	fsmap_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (q_valid),
		.in_item    (q_item),
		.done       (done),
		.speed_diff (speed_diff)
	);

endmodule

// ----- bench/fuzzy_speed_map_checker.sv -----
// Scoreboard for fuzzy_speed_map_core: predicts speed_diff for every accepted sample
// and checks each result beat against the oldest prediction.
// Standalone; it watches the core's ports only and carries its own copy of the tables.
module fuzzy_speed_map_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [11:0] complexity,
	input  logic signed [11:0] lookahead,
	input  logic               done,
	input  logic signed [9:0]  speed_diff,
	output int                 outstanding,
	output int                 fails
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SPEED_RULE [91] = '{
		4, 1, 0, 0, 0, 0, 0,
		4, 1, 1, 0, 0, 0, 0,
		5, 2, 1, 1, 0, 0, 0,
		5, 3, 2, 1, 1, 0, 0,
		6, 4, 3, 2, 1, 1, 0,
		6, 5, 4, 3, 2, 1, 1,
		6, 6, 6, 6, 6, 6, 6,
		6, 7, 8, 9, 10, 11, 11,
		6, 8, 9, 10, 11, 11, 12,
		7, 9, 10, 11, 11, 12, 12,
		7, 10, 11, 11, 12, 12, 12,
		8, 11, 11, 12, 12, 12, 12,
		8, 11, 12, 12, 12, 12, 12
	};

	localparam int SPEED_LEVEL [13] = '{
		-350, -290, -240, -180, -130, -70, 0, 70, 130, 180, 240, 290, 350
	};

	logic signed [9:0] expected_speed [$];

	function automatic int grid_segment(input int x, input int step, input int segs,
			output int lower);
		int n;
		if (x <= 2) begin
			lower = 100;
			return 1;
		end
		if (x >= 98) begin
			lower = 0;
			return segs;
		end
		n = (x - 2 + step - 1) / step;
		if (n < 1) begin
			n = 1;
		end
		if (n > segs) begin
			n = segs;
		end
		lower = (100 * (2 + step * n - x)) / step;
		return n;
	endfunction

	function automatic int rule_level(input int pi, input int di);
		int r;
		r = SPEED_RULE[pi * 7 + di];
		if (r > 12) begin
			r = 12;
		end
		return SPEED_LEVEL[r];
	endfunction

	function automatic logic signed [9:0] predict_speed_diff(input logic signed [11:0] cx,
			input logic signed [11:0] lx);
		int c, l, p, d, pn, dn, pf0, df0, pf1, df1;
		int u0, u1, u2, u3, t1, t2, acc;
		c = cx;
		l = lx;
		if (c < -110) begin
			c = -110;
		end
		if (c > 110) begin
			c = 110;
		end
		if (l < 0) begin
			l = 0;
		end
		if (l > 45) begin
			l = 45;
		end
		p = ((c + 110) * 24) / 55 + 2;
		d = (l * 32) / 15 + 2;
		pn = grid_segment(p, 8, 12, pf0);
		dn = grid_segment(d, 16, 6, df0);
		pf1 = 100 - pf0;
		df1 = 100 - df0;
		u0 = rule_level(pn - 1, dn - 1);
		u1 = rule_level(pn, dn - 1);
		u2 = rule_level(pn - 1, dn);
		u3 = rule_level(pn, dn);
		t1 = 100 * u0 + df1 * (u2 - u0);
		t2 = 100 * u1 + df1 * (u3 - u1);
		acc = 100 * t1 + pf1 * (t2 - t1);
		return 10'(acc / 10000);
	endfunction

	always @(posedge clk) begin
		logic signed [9:0] want;
		if (arst_n) begin
			if (done) begin
				if (expected_speed.size() == 0) begin
					$error("speed_diff beat with no sample pending: actual %0d", speed_diff);
					fails = fails + 1;
				end else begin
					want = expected_speed.pop_front();
					if (speed_diff !== want) begin
						$error("speed_diff mismatch: expected %0d, actual %0d", want, speed_diff);
						fails = fails + 1;
					end
				end
			end
			if (start && !busy) begin
				expected_speed.push_back(predict_speed_diff(complexity, lookahead));
			end
			outstanding = expected_speed.size();
		end
	end

endmodule

// ----- bench/tb_fuzzy_speed_map_core.sv -----
// Testbench top for fuzzy_speed_map_core: drives directed and random samples with
// varying gaps and gives the verdict.
// Depends on fuzzy_speed_map_core and fuzzy_speed_map_checker.
module tb_fuzzy_speed_map_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_PER_PHASE = 200;
	localparam int DIRECTED = 18;

	localparam int DIR_C [DIRECTED] = '{
		-2048, 2047, -110, 110, -111, 111, 0, -91, -91, 0,
		-2048, 2047, -1, 1, 100, -100, -1366, 1365
	};
	localparam int DIR_L [DIRECTED] = '{
		-2048, 2047, 0, 45, 46, -1, 22, 15, 30, 8,
		2047, -2048, 1, 44, 7, 38, 1365, -1366
	};

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [11:0] complexity;
	logic signed [11:0] lookahead;
	logic               done;
	logic signed [9:0]  speed_diff;
	int                 outstanding;
	int                 fails;
	int                 cycle_count;

	fuzzy_speed_map_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.complexity (complexity),
		.lookahead  (lookahead),
		.done       (done),
		.speed_diff (speed_diff)
	);

	fuzzy_speed_map_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.complexity  (complexity),
		.lookahead   (lookahead),
		.done        (done),
		.speed_diff  (speed_diff),
		.outstanding (outstanding),
		.fails       (fails)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("fuzzy_speed_map_core test failed");
			$finish;
		end
	end

	task automatic send_sample(input logic signed [11:0] c, input logic signed [11:0] l,
			input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		complexity <= c;
		lookahead <= l;
		@(negedge clk);
		while (busy) begin
			@(negedge clk);
		end
		@(posedge clk);
	endtask

	task automatic send_random(input int idle_pct);
		logic signed [11:0] c;
		logic signed [11:0] l;
		c = ($urandom_range(9) == 0) ? 12'($urandom) : 12'(int'($urandom_range(260)) - 130);
		l = ($urandom_range(9) == 0) ? 12'($urandom) : 12'(int'($urandom_range(55)) - 5);
		send_sample(c, l, idle_pct);
	endtask

	// Holds start low until every accepted sample has produced its result.
	task automatic drain_results();
		start <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) begin
			@(negedge clk);
		end
		@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		complexity = '0;
		lookahead = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED; i++) begin
			send_sample(12'(DIR_C[i]), 12'(DIR_L[i]), 36);
		end
		for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
			send_random(36);
		end
		drain_results();
		for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
			send_random(65);
		end
		drain_results();
		for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
			send_random(0);
		end
		drain_results();
		repeat (12) @(posedge clk);

		if (fails == 0) begin
			$display("fuzzy_speed_map_core test passed");
		end else begin
			$display("fuzzy_speed_map_core test failed");
		end
		$finish;
	end

endmodule
